FILE: design/gyro_frame_median_filter_assert.svh
// ----------------------------------------------------------------------------
// Gyro frame median filter assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GYRO_FRAME_MEDIAN_FILTER_ASSERT_SVH
`define GYRO_FRAME_MEDIAN_FILTER_ASSERT_SVH

// Same-cycle implication
`define GFMF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gfmf: same-cycle check failed");

// Next-cycle implication
`define GFMF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gfmf: next-cycle check failed");

`endif

FILE: design/gfmf_pkg.sv
// ----------------------------------------------------------------------------
// Gyro frame median filter package
// Shared widths, reset values, codes and the frame struct.
// ----------------------------------------------------------------------------
package gfmf_pkg;

  localparam int ByteW  = 8;
  localparam int AngleW = 10;
  localparam int CfgIdxW = 1;

  typedef logic [ByteW-1:0]         byte_t;
  typedef logic signed [AngleW-1:0] angle_t;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxSync  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxPitch = 1'b1;

  // Register reset values and flag code
  localparam byte_t SyncReset     = 8'd100;
  localparam byte_t PitchOffReset = 8'd17;
  localparam byte_t FlagNegative  = 8'hFF;

  // Parser to window/output interface
  typedef struct packed {
    logic   push;     // frame complete this cycle
    logic   at_last;  // parser expects the last payload byte
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
  } gfmf_frame_t;

endpackage

FILE: design/gfmf_parser.sv
// ----------------------------------------------------------------------------
// Gyro frame parser
// Hunts for the double sync byte, then collects flag/value pairs for
// roll, pitch and yaw and reports the finished frame angles.
// ----------------------------------------------------------------------------
module gfmf_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  gfmf_pkg::byte_t     byte_i,
  input  gfmf_pkg::byte_t     sync_i,
  input  gfmf_pkg::byte_t     pitch_off_i,
  output gfmf_pkg::gfmf_frame_t frame_o
);
  import gfmf_pkg::*;

  typedef enum logic [3:0] {
    PhHunt1 = 4'd0,
    PhHunt2 = 4'd1,
    PhPay0  = 4'd2,
    PhPay1  = 4'd3,
    PhPay2  = 4'd4,
    PhPay3  = 4'd5,
    PhPay4  = 4'd6,
    PhPay5  = 4'd7
  } phase_e;

  phase_e phase_q, phase_d;
  byte_t  flag_q, flag_d;
  angle_t roll_q, roll_d;
  angle_t pitch_q, pitch_d;
  angle_t raw_angle;
  angle_t pitch_angle;
  logic   is_sync;

  // Sign-extend the value byte by its flag
  assign raw_angle   = (flag_q == FlagNegative) ? angle_t'({2'b11, byte_i})
                                                : angle_t'({2'b00, byte_i});
  assign pitch_angle = raw_angle - angle_t'({2'b00, pitch_off_i});
  assign is_sync     = (byte_i == sync_i);

  // Advance the frame phase
  always_comb begin
    phase_d = phase_q;
    flag_d  = flag_q;
    roll_d  = roll_q;
    pitch_d = pitch_q;
    if (fire_i) begin
      unique case (phase_q)
        PhHunt2: phase_d = is_sync ? PhPay0 : PhHunt1;
        PhPay0: begin
          flag_d  = byte_i;
          phase_d = PhPay1;
        end
        PhPay1: begin
          roll_d  = raw_angle;
          phase_d = PhPay2;
        end
        PhPay2: begin
          flag_d  = byte_i;
          phase_d = PhPay3;
        end
        PhPay3: begin
          pitch_d = pitch_angle;
          phase_d = PhPay4;
        end
        PhPay4: begin
          flag_d  = byte_i;
          phase_d = PhPay5;
        end
        PhPay5:  phase_d = PhHunt1;
        default: phase_d = is_sync ? PhHunt2 : PhHunt1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt1;
      flag_q  <= '0;
      roll_q  <= '0;
      pitch_q <= '0;
    end else begin
      phase_q <= phase_d;
      flag_q  <= flag_d;
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
    end
  end

  // Report the frame; yaw comes straight from the last value byte
  assign frame_o.at_last = (phase_q == PhPay5);
  assign frame_o.push    = fire_i && (phase_q == PhPay5);
  assign frame_o.roll    = roll_q;
  assign frame_o.pitch   = pitch_q;
  assign frame_o.yaw     = raw_angle;

endmodule

FILE: design/gfmf_window.sv
// ----------------------------------------------------------------------------
// Gyro angle median window
// Shift register of recent angles with a rank-select median network.
// ----------------------------------------------------------------------------
module gfmf_window #(
  parameter int Depth = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gfmf_pkg::angle_t angle_i,
  output gfmf_pkg::angle_t median_o
);
  import gfmf_pkg::*;

  localparam int RankW = $clog2(Depth);
  localparam logic [RankW-1:0] MidRank = RankW'(Depth / 2);

  angle_t win_q [Depth];
  angle_t win_nxt [Depth];
  logic [RankW-1:0] rank [Depth];
  angle_t median;

  // Shift out the oldest, append the newest at the top
  always_comb begin
    for (int i = 0; i < Depth - 1; i++) begin
      win_nxt[i] = win_q[i+1];
    end
    win_nxt[Depth-1] = angle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        win_q[i] <= '0;
      end
    end else if (push_i) begin
      win_q <= win_nxt;
    end
  end

  // Stable rank of each entry: ties broken by position
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      rank[i] = '0;
      for (int j = 0; j < Depth; j++) begin
        if ((win_nxt[j] < win_nxt[i]) || ((win_nxt[j] == win_nxt[i]) && (j < i))) begin
          rank[i] = rank[i] + RankW'(1);
        end
      end
    end
  end

  // Pick the entry of middle rank
  always_comb begin
    median = '0;
    for (int i = 0; i < Depth; i++) begin
      if (rank[i] == MidRank) begin
        median = median | win_nxt[i];
      end
    end
  end

  assign median_o = median;

endmodule

FILE: design/gyro_frame_median_filter.sv
// ----------------------------------------------------------------------------
// Gyro frame median filter
// Parses gyro frames and emits the windowed median of roll, pitch and yaw.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle. When the last payload byte of a frame is
// accepted, the angles enter their windows and the three medians appear in
// the result register on the next cycle. The only stall: the last payload
// byte waits while a previous result is still held and not taken. The
// median network is a single rank-select stage fed by the shifted window.
`include "gyro_frame_median_filter_assert.svh"

module gyro_frame_median_filter #(
  parameter int WINDOW_DEPTH = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gfmf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  gfmf_pkg::byte_t               cfg_wdata_i,
  input  logic                          rx_valid_i,
  output logic                          rx_ready_o,
  input  gfmf_pkg::byte_t               rx_byte_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output gfmf_pkg::angle_t              roll_median_o,
  output gfmf_pkg::angle_t              pitch_median_o,
  output gfmf_pkg::angle_t              yaw_median_o
);
  import gfmf_pkg::*;

  byte_t       sync_q, sync_d;
  byte_t       poff_q, poff_d;
  gfmf_frame_t frame;
  logic        fire;
  angle_t      roll_med, pitch_med, yaw_med;
  logic        res_valid_q, res_valid_d;
  angle_t      roll_q, pitch_q, yaw_q;

  // Configuration registers
  always_comb begin
    sync_d = sync_q;
    poff_d = poff_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxSync:  sync_d = cfg_wdata_i;
        CfgIdxPitch: poff_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SyncReset;
      poff_q <= PitchOffReset;
    end else begin
      sync_q <= sync_d;
      poff_q <= poff_d;
    end
  end

  // Hold only the frame-ending request while a result waits
  assign rx_ready_o = !(frame.at_last && res_valid_q && !res_ready_i);
  assign fire       = rx_valid_i && rx_ready_o;

  gfmf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (rx_byte_i),
    .sync_i      (sync_q),
    .pitch_off_i (poff_q),
    .frame_o     (frame)
  );

  gfmf_window #(.Depth(WINDOW_DEPTH)) u_roll_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (frame.push),
    .angle_i  (frame.roll),
    .median_o (roll_med)
  );

  gfmf_window #(.Depth(WINDOW_DEPTH)) u_pitch_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (frame.push),
    .angle_i  (frame.pitch),
    .median_o (pitch_med)
  );

  gfmf_window #(.Depth(WINDOW_DEPTH)) u_yaw_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (frame.push),
    .angle_i  (frame.yaw),
    .median_o (yaw_med)
  );

  // Result register: load on frame end, drop when taken
  always_comb begin
    res_valid_d = res_valid_q;
    if (frame.push) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame.push) begin
      roll_q  <= roll_med;
      pitch_q <= pitch_med;
      yaw_q   <= yaw_med;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign roll_median_o  = roll_q;
  assign pitch_median_o = pitch_q;
  assign yaw_median_o   = yaw_q;

  // A frame never overwrites a result that is still waiting
  `GFMF_ASSERT_IMP(a_no_overwrite, frame.push, !res_valid_q || res_ready_i)
  // A completed frame always shows up as a result
  `GFMF_ASSERT_NXT(a_push_shows, frame.push, res_valid_q)
  // Input stalls only behind a held result
  `GFMF_ASSERT_IMP(a_stall_cause, !rx_ready_o, res_valid_q && frame.at_last)

endmodule

FILE: dv/tb_gyro_frame_median_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro frame median filter testbench
// Feeds sync-framed gyro byte streams through the valid/ready request port,
// tracks the parser and the three five-deep windows in a local predictor and
// checks every median triple against it, under random gaps and stalls and
// across several sync and pitch offset settings.
// ----------------------------------------------------------------------------
module tb_gyro_frame_median_filter;
  import gfmf_pkg::*;

  localparam int Depth      = 5;
  localparam int CycleLimit = 400000;

  // Parser positions: two sync hunts, then six payload bytes
  localparam int PhHunt1 = 0;
  localparam int PhHunt2 = 1;
  localparam int PhPay0  = 2;
  localparam int PhLast  = 7;

  localparam int AxRoll  = 0;
  localparam int AxPitch = 1;
  localparam int AxYaw   = 2;

  typedef struct packed {
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
  } medians_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx   = CfgIdxSync;
  byte_t                cfg_wdata = '0;
  logic                 rx_valid  = 1'b0;
  byte_t                rx_byte   = '0;
  logic                 res_ready = 1'b0;
  logic                 rx_ready_o;
  logic                 res_valid_o;
  angle_t               roll_median_o;
  angle_t               pitch_median_o;
  angle_t               yaw_median_o;

  // Stimulus and checking state
  byte_t    pending_bytes[$];
  medians_t expected_medians[$];
  logic     idle_en = 1'b1;
  int       gap_left = 0;
  int       stall_left = 0;
  int       errors = 0;
  int       cycles = 0;

  // Predictor state
  byte_t  sync_mdl;
  byte_t  pitch_off_mdl;
  int     phase_mdl;
  byte_t  flag_mdl;
  angle_t frame_mdl [3];
  angle_t win_mdl [3][Depth];

  gyro_frame_median_filter #(.WINDOW_DEPTH(Depth)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .rx_valid_i     (rx_valid),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready),
    .roll_median_o  (roll_median_o),
    .pitch_median_o (pitch_median_o),
    .yaw_median_o   (yaw_median_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sort a copy of one window and take the middle entry
  function automatic angle_t window_mid(input int ax);
    angle_t s [Depth];
    angle_t v;
    int j;
    for (int i = 0; i < Depth; i++) begin
      v = win_mdl[ax][i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    return s[Depth/2];
  endfunction

  // Advance the predicted parser by one accepted byte
  task automatic parse_rx_byte(input byte_t b);
    angle_t   a;
    medians_t m;
    int       k;
    int       ax;
    if (phase_mdl == PhHunt2) begin
      phase_mdl = (b == sync_mdl) ? PhPay0 : PhHunt1;
    end else if (phase_mdl < PhPay0 || phase_mdl > PhLast) begin
      phase_mdl = (b == sync_mdl) ? PhHunt2 : PhHunt1;
    end else begin
      k  = phase_mdl - PhPay0;
      ax = k / 2;
      if (k % 2 == 0) begin
        flag_mdl  = b;
        phase_mdl = phase_mdl + 1;
      end else begin
        a = angle_t'({2'b00, b});
        if (flag_mdl == FlagNegative) a = a - angle_t'(256);
        if (ax == AxPitch) a = a - angle_t'({2'b00, pitch_off_mdl});
        frame_mdl[ax] = a;
        if (phase_mdl != PhLast) begin
          phase_mdl = phase_mdl + 1;
        end else begin
          phase_mdl = PhHunt1;
          for (int w = 0; w < 3; w++) begin
            for (int i = 0; i < Depth - 1; i++) win_mdl[w][i] = win_mdl[w][i+1];
            win_mdl[w][Depth-1] = frame_mdl[w];
          end
          m.roll  = window_mid(AxRoll);
          m.pitch = window_mid(AxPitch);
          m.yaw   = window_mid(AxYaw);
          expected_medians.push_back(m);
        end
      end
    end
  endtask

  task automatic reset_model();
    sync_mdl      = SyncReset;
    pitch_off_mdl = PitchOffReset;
    phase_mdl     = PhHunt1;
    flag_mdl      = '0;
    for (int w = 0; w < 3; w++) begin
      frame_mdl[w] = '0;
      for (int i = 0; i < Depth; i++) win_mdl[w][i] = '0;
    end
  endtask

  // Driver: present queued bytes, with random gaps between requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid <= 1'b0;
      rx_byte  <= '0;
      gap_left <= 0;
    end else begin
      if (rx_valid && rx_ready_o) parse_rx_byte(rx_byte);
      if (!rx_valid || rx_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          rx_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          rx_byte  <= pending_bytes.pop_front();
          rx_valid <= 1'b1;
          if (idle_en && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 13);
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take results with random stalls and compare each field
  always @(posedge clk_i or negedge rst_ni) begin
    medians_t m;
    if (!rst_ni) begin
      res_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_valid_o && res_ready) begin
        if (expected_medians.size() == 0) begin
          $display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d", $time,
                   roll_median_o, pitch_median_o, yaw_median_o);
          errors++;
        end else begin
          m = expected_medians.pop_front();
          if (roll_median_o !== m.roll) begin
            $display("%0t: roll_median expected %0d actual %0d", $time, m.roll, roll_median_o);
            errors++;
          end
          if (pitch_median_o !== m.pitch) begin
            $display("%0t: pitch_median expected %0d actual %0d", $time, m.pitch,
                     pitch_median_o);
            errors++;
          end
          if (yaw_median_o !== m.yaw) begin
            $display("%0t: yaw_median expected %0d actual %0d", $time, m.yaw, yaw_median_o);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        res_ready  <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 12);
        res_ready  <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_gyro_frame_median_filter failed");
      $finish;
    end
  end

  task automatic queue_frame(input byte_t s, input byte_t rf, input byte_t rv,
                             input byte_t pf, input byte_t pv, input byte_t yf,
                             input byte_t yv);
    pending_bytes.push_back(s);
    pending_bytes.push_back(s);
    pending_bytes.push_back(rf);
    pending_bytes.push_back(rv);
    pending_bytes.push_back(pf);
    pending_bytes.push_back(pv);
    pending_bytes.push_back(yf);
    pending_bytes.push_back(yv);
  endtask

  function automatic byte_t pick_flag();
    case ($urandom_range(0, 3))
      0, 1:    return FlagNegative;
      2:       return 8'h00;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic byte_t pick_value();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed frames, plus noise, broken syncs and a repeated sync
  task automatic queue_traffic(input int n_bytes);
    int    sent;
    byte_t s;
    sent = 0;
    s    = sync_mdl;
    while (sent < n_bytes) begin
      case ($urandom_range(0, 9))
        7: pending_bytes.push_back(byte_t'($urandom_range(0, 255)));
        8: begin
          pending_bytes.push_back(s);
          pending_bytes.push_back(s + byte_t'($urandom_range(1, 255)));
        end
        9: begin
          // extra leading sync byte is taken as the roll flag
          pending_bytes.push_back(s);
          queue_frame(s, s, pick_value(), pick_flag(), pick_value(), pick_flag(),
                      pick_value());
          sent += 8;
        end
        default: begin
          queue_frame(s, pick_flag(), pick_value(), pick_flag(), pick_value(),
                      pick_flag(), pick_value());
          sent += 8;
        end
      endcase
    end
  endtask

  // Hold the sender until every byte is taken and every result has come
  task automatic drain();
    while (pending_bytes.size() != 0 || rx_valid || expected_medians.size() != 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_regs(input byte_t s, input byte_t off);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgIdxSync;
    cfg_wdata <= s;
    @(posedge clk_i);
    cfg_idx   <= CfgIdxPitch;
    cfg_wdata <= off;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sync_mdl      = s;
    pitch_off_mdl = off;
    @(negedge clk_i);
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes under reset settings, broken sync, payload equal to sync
    queue_frame(SyncReset, FlagNegative, 8'h00, FlagNegative, 8'h00, FlagNegative, 8'h00);
    queue_frame(SyncReset, 8'hFE, 8'hFF, 8'h00, 8'hFF, 8'h7F, 8'hFF);
    pending_bytes.push_back(SyncReset);
    pending_bytes.push_back(8'h07);
    queue_frame(SyncReset, SyncReset, SyncReset, SyncReset, SyncReset, SyncReset, SyncReset);
    drain();

    // Lowest sync, largest offset: most negative pitch first
    write_regs(8'h00, 8'hFF);
    @(negedge clk_i);
    queue_frame(8'h00, FlagNegative, 8'h00, FlagNegative, 8'h00, FlagNegative, 8'h00);
    queue_traffic(150);
    drain();

    write_regs(8'hFF, 8'h00);
    queue_traffic(150);
    drain();

    write_regs(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)));
    queue_traffic(150);
    drain();

    // Final stretch at full rate on both sides
    idle_en <= 1'b0;
    write_regs(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)));
    queue_traffic(150);
    drain();
    repeat (10) @(posedge clk_i);

    if (errors == 0 && expected_medians.size() == 0) begin
      $display("tb_gyro_frame_median_filter passed");
    end else begin
      $display("tb_gyro_frame_median_filter failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/gfmf_pkg.sv
design/gfmf_parser.sv
design/gfmf_window.sv
design/gyro_frame_median_filter.sv
dv/tb_gyro_frame_median_filter.sv
